// File: hdl/psev_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the postfix stack evaluator.
// No dependencies.
package psev_pkg;

  localparam int DATA_W      = 32;
  localparam int DEPTH_OUT_W = 7;
  localparam int DEF_STACK_DEPTH = 64;

  typedef enum logic [2:0] {
    OP_PUSH = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_BAD   = 3'd1,
    ST_UNDER = 3'd2,
    ST_OVER  = 3'd3,
    ST_DIVZ  = 3'd4
  } status_t;

  // what a stack cell does this cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_TAKE_UP,
    CELL_TAKE_DOWN
  } cell_cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_DONE
  } state_t;

endpackage

// File: hdl/psev_cell.sv
`timescale 1ns / 1ps
// One stack entry: holds, or loads from the entry above or below.
// Depends on psev_pkg.
module psev_cell (
  input  logic                             clk,
  input  psev_pkg::cell_cmd_t              cmd,
  input  logic [psev_pkg::DATA_W-1:0]      up_data,
  input  logic [psev_pkg::DATA_W-1:0]      down_data,
  output logic [psev_pkg::DATA_W-1:0]      data_q
);
  import psev_pkg::*;

  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] data_nxt;

  always_comb begin
    unique case (cmd)
      CELL_TAKE_UP:   data_nxt = up_data;
      CELL_TAKE_DOWN: data_nxt = down_data;
      default:        data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q = data_r;

endmodule

// File: hdl/psev_div.sv
`timescale 1ns / 1ps
// Signed 32-bit divider, truncating toward zero, one quotient bit per cycle.
// Depends on psev_pkg.
module psev_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [psev_pkg::DATA_W-1:0]      dividend,
  input  logic [psev_pkg::DATA_W-1:0]      divisor,
  output logic                             done,
  output logic [psev_pkg::DATA_W-1:0]      quotient
);
  import psev_pkg::*;

  localparam int CNT_W = $clog2(DATA_W);

  logic              run_r, run_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [DATA_W-1:0] quo_r, quo_nxt;
  logic [DATA_W-1:0] den_r, den_nxt;
  logic              neg_r, neg_nxt;
  logic [DATA_W-1:0] q_r, q_nxt;
  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   diff;
  logic              ge;
  logic [DATA_W-1:0] quo_step;

  assign shifted  = {rem_r, quo_r[DATA_W-1]};
  assign diff     = shifted - {1'b0, den_r};
  assign ge       = !diff[DATA_W];
  assign quo_step = {quo_r[DATA_W-2:0], ge};

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    q_nxt    = q_r;
    priority if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      rem_nxt = '0;
      quo_nxt = dividend[DATA_W-1] ? (DATA_W'(0) - dividend) : dividend;
      den_nxt = divisor[DATA_W-1] ? (DATA_W'(0) - divisor) : divisor;
      neg_nxt = dividend[DATA_W-1] ^ divisor[DATA_W-1];
    end else if (run_r) begin
      rem_nxt = ge ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
      quo_nxt = quo_step;
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(DATA_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
        q_nxt    = neg_r ? (DATA_W'(0) - quo_step) : quo_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
    q_r   <= q_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

// File: hdl/postfix_stack_evaluator_top.sv
`timescale 1ns / 1ps
// Postfix evaluator: a row of shifting stack cells plus a serial divider.
// Push, add, subtract, multiply and error tokens: strobe the cycle after accept.
// Divide (no error): strobe after the 32-step serial divider finishes and the quotient is written back.
// busy is high from accept until the result cycle ends; one token in flight.
// Synchronous active-low reset empties the stack and clears the error.
// Depends on psev_pkg, psev_cell, psev_div.
module postfix_stack_evaluator_top #(
  parameter int STACK_DEPTH = psev_pkg::DEF_STACK_DEPTH
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [2:0]                            in_operation,
  input  logic signed [psev_pkg::DATA_W-1:0]    in_operand_value,
  input  logic                                  in_end_of_expression,
  output logic                                  out_valid,
  output logic signed [psev_pkg::DATA_W-1:0]    out_top_value,
  output logic [psev_pkg::DEPTH_OUT_W-1:0]      out_stack_depth,
  output logic [2:0]                            out_status,
  output logic                                  out_expression_done
);
  import psev_pkg::*;

  localparam int SP_W = $clog2(STACK_DEPTH + 1);

  state_t            state_r, state_nxt;
  logic [SP_W-1:0]   sp_r, sp_nxt;
  status_t           err_r, err_nxt;
  logic              last_r, last_nxt;

  cell_cmd_t         top_cmd;
  cell_cmd_t         rest_cmd;
  logic [DATA_W-1:0] top_in;
  logic [DATA_W-1:0] cell_q [STACK_DEPTH];

  logic              accept;
  logic              div_start;
  logic              div_done;
  logic [DATA_W-1:0] div_q;
  logic [DATA_W-1:0] lhs, rhs;
  logic [DATA_W-1:0] alu_res;
  logic [DATA_W-1:0] mul_lo;
  logic              full, short;
  logic [31:0]       sp_ext;

  assign accept = start && (state_r == S_IDLE);
  assign rhs    = cell_q[0];
  assign lhs    = cell_q[1];
  assign mul_lo = lhs * rhs;
  assign full   = (sp_r == SP_W'(STACK_DEPTH));
  assign short  = (sp_r < SP_W'(2));

  always_comb begin
    unique case (op_t'(in_operation))
      OP_ADD:  alu_res = lhs + rhs;
      OP_SUB:  alu_res = lhs - rhs;
      default: alu_res = mul_lo;
    endcase
  end

  // stack cells: cell 0 is the top
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] up_d;
    logic [DATA_W-1:0] down_d;
    if (i == 0) begin : g_top
      assign up_d = top_in;
    end else begin : g_mid
      assign up_d = cell_q[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_end
      assign down_d = cell_q[i];
    end else begin : g_below
      assign down_d = cell_q[i+1];
    end
    psev_cell u_cell (
      .clk       (clk),
      .cmd       ((i == 0) ? top_cmd : rest_cmd),
      .up_data   (up_d),
      .down_data (down_d),
      .data_q    (cell_q[i])
    );
  end

  psev_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (lhs),
    .divisor  (rhs),
    .done     (div_done),
    .quotient (div_q)
  );

  // token execution
  always_comb begin
    top_cmd   = CELL_HOLD;
    rest_cmd  = CELL_HOLD;
    top_in    = in_operand_value;
    sp_nxt    = sp_r;
    err_nxt   = err_r;
    last_nxt  = last_r;
    div_start = 1'b0;
    priority if (accept) begin
      last_nxt = in_end_of_expression;
      if (err_r == ST_OK) begin
        unique case (op_t'(in_operation))
          OP_PUSH: begin
            if (full) begin
              err_nxt = ST_OVER;
            end else begin
              top_cmd  = CELL_TAKE_UP;
              rest_cmd = CELL_TAKE_UP;
              sp_nxt   = sp_r + SP_W'(1);
            end
          end
          OP_ADD, OP_SUB, OP_MUL: begin
            if (short) begin
              err_nxt = ST_UNDER;
            end else begin
              top_cmd  = CELL_TAKE_UP;
              top_in   = alu_res;
              rest_cmd = CELL_TAKE_DOWN;
              sp_nxt   = sp_r - SP_W'(1);
            end
          end
          OP_DIV: begin
            if (short) begin
              err_nxt = ST_UNDER;
            end else if (rhs == '0) begin
              err_nxt = ST_DIVZ;
            end else begin
              div_start = 1'b1;
            end
          end
          default: err_nxt = ST_BAD;
        endcase
      end
    end else if (state_r == S_DIV && div_done) begin
      top_cmd  = CELL_TAKE_UP;
      top_in   = div_q;
      rest_cmd = CELL_TAKE_DOWN;
      sp_nxt   = sp_r - SP_W'(1);
    end else if (state_r == S_DONE && last_r) begin
      sp_nxt  = '0;
      err_nxt = ST_OK;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept) state_nxt = div_start ? S_DIV : S_DONE;
      S_DIV:   if (div_done) state_nxt = S_DONE;
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sp_r    <= '0;
      err_r   <= ST_OK;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sp_r    <= sp_nxt;
      err_r   <= err_nxt;
      last_r  <= last_nxt;
    end
  end

  assign sp_ext = 32'(sp_r);

  always_comb begin
    busy                = (state_r != S_IDLE);
    out_valid           = (state_r == S_DONE);
    out_top_value       = (sp_r != '0) ? cell_q[0] : '0;
    out_stack_depth     = sp_ext[DEPTH_OUT_W-1:0];
    out_status          = err_r;
    out_expression_done = last_r;
  end

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SP_W'(STACK_DEPTH))
    else $error("stack pointer beyond depth");

  a_err_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && err_r != ST_OK) |=> $stable(sp_r))
    else $error("stack changed while error pending");

  a_end_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_expression_done) |=> (sp_r == '0 && err_r == ST_OK))
    else $error("end of expression did not clear");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("divider finished outside divide");

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for postfix_stack_evaluator_top: directed and random token streams.
// Shadow stack predicts each result; the monitor checks fields in order. Depends on psev_pkg.
module tb_top;
  import psev_pkg::*;

  localparam int TB_DEPTH = DEF_STACK_DEPTH;
  localparam logic [2:0] FIRST_BAD_OP = 3'd5;
  localparam logic [2:0] LAST_BAD_OP  = 3'd7;

  typedef struct {
    logic [2:0]  op;
    logic [31:0] value;
    logic        last;
    bit          drain_first;
  } token_t;

  typedef struct {
    logic [31:0] top;
    logic [6:0]  depth;
    status_t     status;
    logic        done;
  } token_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic [2:0]  in_operation = '0;
  logic [31:0] in_operand_value = '0;
  logic        in_end_of_expression = 1'b0;
  logic        busy;
  logic        out_valid;
  logic [31:0] out_top_value;
  logic [6:0]  out_stack_depth;
  logic [2:0]  out_status;
  logic        out_expression_done;

  // pending requests and results still owed by the block
  token_t        token_q[$];
  token_result_t expected_result_q[$];
  logic          took = 1'b0;
  int            mismatches = 0;
  int            burst_left = 1;
  int            gap_left = 0;

  logic [31:0] shadow_stack [TB_DEPTH];
  int          shadow_sp = 0;
  status_t     shadow_err = ST_OK;

  postfix_stack_evaluator_top #(.STACK_DEPTH(TB_DEPTH)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_operation(in_operation),
    .in_operand_value(in_operand_value),
    .in_end_of_expression(in_end_of_expression),
    .out_valid(out_valid),
    .out_top_value(out_top_value),
    .out_stack_depth(out_stack_depth),
    .out_status(out_status),
    .out_expression_done(out_expression_done)
  );

  always #4 clk = ~clk;

  function automatic logic [31:0] trunc_quotient(logic [31:0] a, logic [31:0] b);
    logic [31:0] ma;
    logic [31:0] mb;
    logic [31:0] q;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q = ma / mb;
    return (a[31] ^ b[31]) ? -q : q;
  endfunction

  function automatic token_result_t eval_token(logic [2:0] op, logic [31:0] val, logic last);
    token_result_t r;
    logic [31:0] lhs;
    logic [31:0] rhs;
    logic [31:0] res;
    if (shadow_err == ST_OK) begin
      if (op == OP_PUSH) begin
        if (shadow_sp >= TB_DEPTH) begin
          shadow_err = ST_OVER;
        end else begin
          shadow_stack[shadow_sp] = val;
          shadow_sp++;
        end
      end else if (op > OP_DIV) begin
        shadow_err = ST_BAD;
      end else if (shadow_sp < 2) begin
        shadow_err = ST_UNDER;
      end else begin
        rhs = shadow_stack[shadow_sp - 1];
        lhs = shadow_stack[shadow_sp - 2];
        if (op == OP_DIV && rhs == 32'd0) begin
          shadow_err = ST_DIVZ;
        end else begin
          case (op)
            OP_ADD: res = lhs + rhs;
            OP_SUB: res = lhs - rhs;
            OP_MUL: res = lhs * rhs;
            default: res = trunc_quotient(lhs, rhs);
          endcase
          shadow_sp--;
          shadow_stack[shadow_sp - 1] = res;
        end
      end
    end
    r.top = (shadow_sp > 0) ? shadow_stack[shadow_sp - 1] : '0;
    r.depth = 7'(shadow_sp);
    r.status = shadow_err;
    r.done = last;
    if (last) begin
      shadow_sp = 0;
      shadow_err = ST_OK;
    end
    return r;
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'(int'($urandom_range(0, 16)) - 8);
      1: return '0;
      2: return 32'h7FFF_FFFF;
      3: return 32'h8000_0000;
      4: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  task automatic add_token(logic [2:0] op, logic [31:0] val, logic last);
    token_t t;
    t.op = op;
    t.value = val;
    t.last = last;
    t.drain_first = 1'b0;
    token_q.push_back(t);
  endtask

  task automatic add_expression(bit broken);
    token_t seq[$];
    token_t t;
    int depth_now = 0;
    int pushes = $urandom_range(1, 10);
    int cut;
    t.drain_first = 1'b0;
    t.last = 1'b0;
    while (pushes > 0 || depth_now > 1) begin
      t.value = pick_value();
      if (pushes > 0 && (depth_now < 2 || $urandom_range(0, 2) != 0)) begin
        t.op = OP_PUSH;
        pushes--;
        depth_now++;
      end else begin
        t.op = 3'($urandom_range(OP_ADD, OP_DIV));
        depth_now--;
      end
      seq.push_back(t);
    end
    if (broken) begin
      cut = $urandom_range(0, seq.size() - 1);
      case ($urandom_range(0, 2))
        0: begin
          t.op = 3'($urandom_range(FIRST_BAD_OP, LAST_BAD_OP));
          seq.insert(cut, t);
        end
        1: begin
          t.op = 3'($urandom_range(OP_ADD, OP_DIV));
          seq.push_back(t);
        end
        default: begin
          while (seq.size() > cut + 1) void'(seq.pop_back());
        end
      endcase
    end
    seq[seq.size() - 1].last = 1'b1;
    foreach (seq[i]) token_q.push_back(seq[i]);
  endtask

  task automatic add_noise();
    token_t t;
    t.drain_first = 1'b0;
    repeat ($urandom_range(3, 12)) begin
      t.op = 3'($urandom_range(0, 7));
      t.value = $urandom();
      t.last = ($urandom_range(0, 3) == 0);
      token_q.push_back(t);
    end
  endtask

  task automatic add_fill(int pushes);
    repeat (pushes) add_token(OP_PUSH, $urandom(), 1'b0);
    add_token(OP_ADD, $urandom(), 1'b1);
  endtask

  // driver: new request presented at the falling edge
  always @(negedge clk) begin
    token_t nxt;
    if (rst_n && !(start && !took)) begin
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (token_q.size() == 0) begin
        start <= 1'b0;
      end else if (token_q[0].drain_first && (expected_result_q.size() != 0 || busy)) begin
        start <= 1'b0;
      end else begin
        nxt = token_q.pop_front();
        in_operation <= nxt.op;
        in_operand_value <= nxt.value;
        in_end_of_expression <= nxt.last;
        start <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 16);
          case ($urandom_range(0, 2))
            0: gap_left = 0;
            1: gap_left = $urandom_range(1, 4);
            default: gap_left = $urandom_range(5, 40);
          endcase
        end else begin
          burst_left--;
        end
      end
    end
  end

  // accept, predict and check at the rising edge
  always @(posedge clk) begin
    token_result_t want;
    if (!rst_n) begin
      took <= 1'b0;
    end else begin
      took <= start && !busy;
      if (start && !busy) begin
        expected_result_q.push_back(eval_token(in_operation, in_operand_value,
                                               in_end_of_expression));
      end
      if (out_valid) begin
        if (expected_result_q.size() == 0) begin
          $error("unexpected result: top_value %0h stack_depth %0d", out_top_value,
                 out_stack_depth);
          mismatches++;
        end else begin
          want = expected_result_q.pop_front();
          if (out_top_value !== want.top) begin
            $error("top_value: expected %0h, got %0h", want.top, out_top_value);
            mismatches++;
          end
          if (out_stack_depth !== want.depth) begin
            $error("stack_depth: expected %0d, got %0d", want.depth, out_stack_depth);
            mismatches++;
          end
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            mismatches++;
          end
          if (out_expression_done !== want.done) begin
            $error("expression_done: expected %0b, got %0b", want.done, out_expression_done);
            mismatches++;
          end
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int directed_count;
    int first;
    int pick;
    bit forced_drain;

    forced_drain = 1'b1;
    // operator on an empty stack
    add_token(OP_ADD, 32'h0, 1'b1);
    // wrap on add, most negative over minus one, truncation toward zero
    add_token(OP_PUSH, 32'h7FFF_FFFF, 1'b0);
    add_token(OP_PUSH, 32'h0000_0001, 1'b0);
    add_token(OP_ADD, 32'hFFFF_FFFF, 1'b0);
    add_token(OP_PUSH, 32'hFFFF_FFFF, 1'b0);
    add_token(OP_DIV, 32'h0, 1'b0);
    add_token(OP_PUSH, 32'h7FFF_FFFF, 1'b0);
    add_token(OP_SUB, 32'h0, 1'b0);
    add_token(OP_PUSH, 32'hFFFF_FFF9, 1'b0);
    add_token(OP_PUSH, 32'h0000_0002, 1'b0);
    add_token(OP_DIV, 32'h0, 1'b0);
    add_token(OP_MUL, 32'h0, 1'b0);
    add_token(OP_PUSH, 32'h0000_0005, 1'b0);
    add_token(OP_ADD, 32'h0, 1'b1);
    // zero divisor, then a push that the sticky error blocks
    add_token(OP_PUSH, 32'h0000_0005, 1'b0);
    add_token(OP_PUSH, 32'h0000_0000, 1'b0);
    add_token(OP_DIV, 32'h0, 1'b0);
    add_token(OP_PUSH, 32'h1234_5678, 1'b1);
    // invalid symbols
    add_token(FIRST_BAD_OP, 32'h0, 1'b0);
    add_token(OP_PUSH, 32'h1, 1'b0);
    add_token(3'd6, 32'h0, 1'b0);
    add_token(LAST_BAD_OP, 32'hFFFF_FFFF, 1'b1);
    // one operand only
    add_token(OP_PUSH, 32'h0000_0001, 1'b0);
    add_token(OP_SUB, 32'h0, 1'b1);
    directed_count = token_q.size();

    add_fill(TB_DEPTH + 1);
    add_fill(TB_DEPTH);
    while (token_q.size() < directed_count + 900) begin
      first = token_q.size();
      pick = $urandom_range(0, 99);
      if (pick < 2) add_fill($urandom_range(TB_DEPTH - 1, TB_DEPTH + 2));
      else if (pick < 12) add_noise();
      else if (pick < 27) add_expression(1'b1);
      else add_expression(1'b0);
      if (forced_drain || $urandom_range(0, 29) == 0) token_q[first].drain_first = 1'b1;
      forced_drain = 1'b0;
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (token_q.size() != 0 || start || expected_result_q.size() != 0) @(posedge clk);
    repeat (48) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
